>>> hw/rtl/sdt_pkg.sv
// shared types, constants and codes for the byte-stuffing deframer and channel tracker
`timescale 1ns / 1ps
package sdt_pkg;

  localparam int FRAME_BYTES_DEF = 512;

  localparam logic [7:0] FLAG_BYTE   = 8'h7E;
  localparam logic [7:0] ESC_BYTE    = 8'h7D;
  localparam logic [7:0] ESC_XOR     = 8'h20;
  localparam logic [7:0] MSG_DATA_A  = 8'h0F;
  localparam logic [7:0] MSG_DATA_B  = 8'h03;
  localparam logic [7:0] CN4_MASK    = 8'hE0;
  localparam logic [7:0] CN4_CODE    = 8'h20;
  localparam logic [7:0] CN8_MASK    = 8'hC0;
  localparam logic [7:0] CN8_CODE    = 8'h40;
  localparam logic [7:0] CN_NONE     = 8'hFF;
  localparam logic [7:0] CHAN_ID_RST = 8'd5;

  localparam logic RK_PAYLOAD = 1'b0;
  localparam logic RK_END     = 1'b1;

  localparam logic CK_SDCCH4 = 1'b0;
  localparam logic CK_SDCCH8 = 1'b1;

  typedef enum logic [1:0] {
    PS_IDLE  = 2'd0,
    PS_FRAME = 2'd1,
    PS_ESC   = 2'd2
  } parse_state_t;

  // events from the unstuffer for one line byte
  typedef struct packed {
    logic       start;
    logic       keep;
    logic       close;
    logic [7:0] data;
  } unstuff_ev_t;

  // what the frame stage makes of one event
  typedef struct packed {
    logic       pay;
    logic       fin;
    logic [7:0] data;
    logic [8:0] plen;
    logic [7:0] mtype;
    logic       is_data;
    logic [7:0] cn;
  } frame_ev_t;

  typedef struct packed {
    logic        changed;
    logic        kind;
    logic [2:0]  ss;
    logic [2:0]  ts;
    logic [7:0]  cn;
    logic [31:0] count;
  } trk_res_t;

endpackage

>>> hw/rtl/sdt_unstuff.sv
// flag hunt and escape removal state machine
`timescale 1ns / 1ps
module sdt_unstuff
  import sdt_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  logic [7:0]  line_byte,
  output unstuff_ev_t ev
);

  parse_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= PS_IDLE;
    end else if (fire) begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    ev        = '0;
    ev.data   = line_byte;
    unique case (state_r)
      PS_FRAME: begin
        if (line_byte == FLAG_BYTE) begin
          ev.close = 1'b1;
        end else if (line_byte == ESC_BYTE) begin
          state_nxt = PS_ESC;
        end else begin
          ev.keep = 1'b1;
        end
      end
      PS_ESC: begin
        state_nxt = PS_FRAME;
        ev.keep   = 1'b1;
        ev.data   = line_byte ^ ESC_XOR;
      end
      default: begin
        // idle, and the unused code behaves as idle
        state_nxt = PS_IDLE;
        if (line_byte == FLAG_BYTE) begin
          state_nxt = PS_FRAME;
          ev.start  = 1'b1;
        end
      end
    endcase
  end

endmodule

>>> hw/rtl/sdt_frame.sv
// frame length, header capture, payload forwarding and close decision
`timescale 1ns / 1ps
module sdt_frame
  import sdt_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        fire,
  input  unstuff_ev_t ev,
  input  logic [7:0]  accepted_id,
  output frame_ev_t   fev
);

  localparam int LEN_W = $clog2(FRAME_BYTES + 1);
  localparam int PL_W  = (LEN_W > 9) ? LEN_W : 9;

  logic [LEN_W-1:0] len_r, len_nxt;
  logic [7:0]       chan_id_r, chan_id_nxt;
  logic [7:0]       type_r, type_nxt;
  logic [7:0]       cbyte_r, cbyte_nxt;
  logic [PL_W-1:0]  plen_full;
  logic             room;
  logic             id_ok;

  assign room      = len_r < LEN_W'(FRAME_BYTES);
  assign id_ok     = chan_id_r == accepted_id;
  assign plen_full = PL_W'(len_r) - PL_W'(2);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r     <= '0;
      chan_id_r <= '0;
      type_r    <= '0;
      cbyte_r   <= '0;
    end else if (fire) begin
      len_r     <= len_nxt;
      chan_id_r <= chan_id_nxt;
      type_r    <= type_nxt;
      cbyte_r   <= cbyte_nxt;
    end
  end

  always_comb begin
    len_nxt     = len_r;
    chan_id_nxt = chan_id_r;
    type_nxt    = type_r;
    cbyte_nxt   = cbyte_r;
    fev         = '0;
    fev.data    = ev.data;
    fev.plen    = plen_full[8:0];
    fev.mtype   = type_r;
    fev.cn      = cbyte_r;
    fev.is_data = (type_r == MSG_DATA_A || type_r == MSG_DATA_B) && len_r >= LEN_W'(7);
    if (ev.start) begin
      len_nxt = '0;
    end else if (ev.close) begin
      len_nxt = '0;
      fev.fin = (len_r >= LEN_W'(3)) && id_ok;
    end else if (ev.keep && room) begin
      len_nxt = len_r + LEN_W'(1);
      if (len_r == LEN_W'(0)) begin
        chan_id_nxt = ev.data;
      end
      if (len_r == LEN_W'(2)) begin
        type_nxt = ev.data;
      end
      if (len_r == LEN_W'(6)) begin
        cbyte_nxt = ev.data;
      end
      fev.pay = (len_r >= LEN_W'(2)) && id_ok;
    end
  end

endmodule

>>> hw/rtl/sdt_chan_track.sv
// dedicated channel number classification and change counter
`timescale 1ns / 1ps
module sdt_chan_track
  import sdt_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       go,
  input  logic       is_data,
  input  logic [7:0] cn,
  output trk_res_t   trk
);

  logic [7:0]  last_r;
  logic [31:0] count_r;
  logic        is4, is8, changed;

  assign is4     = (cn & CN4_MASK) == CN4_CODE;
  assign is8     = (cn & CN8_MASK) == CN8_CODE;
  assign changed = go && is_data && (is4 || is8) && cn != last_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_r  <= CN_NONE;
      count_r <= '0;
    end else if (changed) begin
      last_r  <= cn;
      count_r <= count_r + 32'd1;
    end
  end

  always_comb begin
    trk         = '0;
    trk.count   = count_r + {31'd0, changed};
    trk.changed = changed;
    if (changed) begin
      trk.kind = is4 ? CK_SDCCH4 : CK_SDCCH8;
      trk.ss   = is4 ? {1'b0, cn[4:3]} : cn[5:3];
      trk.ts   = cn[2:0];
      trk.cn   = cn;
    end
  end

endmodule

>>> hw/rtl/sercomm_deframer_channel_tracker.sv
// top level: byte-stuffing deframer with cut-through payload and channel tracker
//
//   port group   direction  handshake        carries
//   in_*         input      valid / stall    one raw serial line byte
//   out_*        output     valid / stall    payload byte or end-of-frame summary
//   cfg_*        input      write enable     accepted channel id
//
// one line byte per cycle sustained while out_stall does not hold the output; a byte is
// held in the input register and its result is then registered in the output register
// the single-pass path is the unstuffer, the frame-length compare and the
// 32-bit change-counter increment
// synchronous active-low reset; no clearing pass, ready straight after reset
// out_stall holds the output register and stalls the input register only
// when the output register is full and not being taken
`timescale 1ns / 1ps
module sercomm_deframer_channel_tracker
  import sdt_pkg::*;
#(
  parameter int FRAME_BYTES = FRAME_BYTES_DEF
)
(
  input  logic        clk,
  input  logic        rst_n,
  // configuration
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,
  // input channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [7:0]  in_line_byte,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic        out_result_kind,
  output logic [7:0]  out_payload_byte,
  output logic [8:0]  out_payload_length,
  output logic [7:0]  out_message_type,
  output logic        out_channel_changed,
  output logic        out_channel_kind,
  output logic [2:0]  out_subchannel,
  output logic [2:0]  out_timeslot,
  output logic [7:0]  out_channel_number,
  output logic [31:0] out_change_count
);

  // accepted channel id register
  logic [7:0] acc_id_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      acc_id_r <= CHAN_ID_RST;
    end else if (cfg_wr_en) begin
      acc_id_r <= cfg_wr_data;
    end
  end

  // input register
  logic       s1_valid_r, s1_valid_nxt;
  logic [7:0] s1_byte_r;
  logic       adv;       // output register can take a new value
  logic       fire;      // byte in input register is processed this cycle
  logic       in_take;

  assign adv      = !out_valid || !out_stall;
  assign fire     = s1_valid_r && adv;
  assign in_stall = s1_valid_r && !adv;
  assign in_take  = in_valid && !in_stall;

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (fire) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else begin
      s1_valid_r <= s1_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_byte_r <= in_line_byte;
    end
  end

  // single-pass processing
  unstuff_ev_t ev;
  frame_ev_t   fev;
  trk_res_t    trk;

  sdt_unstuff u_unstuff (
    .clk       (clk),
    .rst_n     (rst_n),
    .fire      (fire),
    .line_byte (s1_byte_r),
    .ev        (ev)
  );

  sdt_frame #(
    .FRAME_BYTES (FRAME_BYTES)
  ) u_frame (
    .clk         (clk),
    .rst_n       (rst_n),
    .fire        (fire),
    .ev          (ev),
    .accepted_id (acc_id_r),
    .fev         (fev)
  );

  // tracker only moves on an accepted frame end
  sdt_chan_track u_track (
    .clk     (clk),
    .rst_n   (rst_n),
    .go      (fire && fev.fin),
    .is_data (fev.is_data),
    .cn      (fev.cn),
    .trk     (trk)
  );

  // output register
  logic        out_valid_r;
  logic        kind_r;
  logic [7:0]  pbyte_r;
  logic [8:0]  plen_r;
  logic [7:0]  mtype_r;
  trk_res_t    trk_r;
  logic        res_valid;

  assign res_valid = fev.pay || fev.fin;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (adv) begin
      out_valid_r <= fire && res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      if (fev.fin) begin
        kind_r  <= RK_END;
        pbyte_r <= '0;
        plen_r  <= fev.plen;
        mtype_r <= fev.mtype;
        trk_r   <= trk;
      end else begin
        kind_r  <= RK_PAYLOAD;
        pbyte_r <= fev.data;
        plen_r  <= '0;
        mtype_r <= '0;
        trk_r   <= '0;
      end
    end
  end

  assign out_valid           = out_valid_r;
  assign out_result_kind     = kind_r;
  assign out_payload_byte    = pbyte_r;
  assign out_payload_length  = plen_r;
  assign out_message_type    = mtype_r;
  assign out_channel_changed = trk_r.changed;
  assign out_channel_kind    = trk_r.kind;
  assign out_subchannel      = trk_r.ss;
  assign out_timeslot        = trk_r.ts;
  assign out_channel_number  = trk_r.cn;
  assign out_change_count    = trk_r.count;

endmodule

>>> hw/rtl/sdt_checker.sv
// port-level checks for the deframer, bound to the top level
`timescale 1ns / 1ps
module sdt_checker
  import sdt_pkg::*;
(
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_result_kind,
  input logic [7:0]  out_payload_byte,
  input logic [8:0]  out_payload_length,
  input logic        out_channel_changed,
  input logic [7:0]  out_channel_number,
  input logic [31:0] out_change_count
);

  // a stalled result transaction holds its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_payload_byte)
      && $stable(out_result_kind) && $stable(out_change_count))
    else $error("stalled result changed");

  // a payload byte transaction carries no frame summary
  a_pay_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == RK_PAYLOAD |->
      out_payload_length == 9'd0 && !out_channel_changed && out_change_count == 32'd0)
    else $error("payload transaction with summary fields");

  // an end transaction always has payload and carries a zero payload byte
  a_end_len: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == RK_END |->
      out_payload_length != 9'd0 && out_payload_byte == 8'd0)
    else $error("end transaction with bad length");

  // the channel number is zero unless a change is flagged, and a change never counts zero
  a_chan_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_result_kind == RK_END |->
      (out_channel_changed && out_change_count != 32'd0 && out_channel_number != CN_NONE)
      || (!out_channel_changed && out_channel_number == 8'd0))
    else $error("channel fields inconsistent");

endmodule

bind sercomm_deframer_channel_tracker sdt_checker u_sdt_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_result_kind     (out_result_kind),
  .out_payload_byte    (out_payload_byte),
  .out_payload_length  (out_payload_length),
  .out_channel_changed (out_channel_changed),
  .out_channel_number  (out_channel_number),
  .out_change_count    (out_change_count)
);
